// ===== rtl/rfm_pkg.sv =====
// shared types and constants of the reciprocal frequency meter
// no dependencies; used by the channel interfaces and the core
`default_nettype none

package rfm_pkg;

  localparam int unsigned CAP_W        = 16;
  localparam int unsigned FREQ_W       = 26;
  localparam int unsigned PERIOD_W     = 32;
  localparam int unsigned COUNTER_BITS = 16;
  localparam int unsigned WRAP_BITS    = 16;

  localparam logic [FREQ_W-1:0] REF_CLOCK_RESET = FREQ_W'(3000000);

  localparam logic REQ_WRAP    = 1'b0;
  localparam logic REQ_CAPTURE = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CALC = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/rfm_if.sv =====
// valid/ready channel interfaces for event items and result items
// depends on rfm_pkg for field widths
`default_nettype none

interface rfm_in_if;
  logic                        valid;
  logic                        ready;
  logic                        req_type;
  logic [rfm_pkg::CAP_W-1:0]   capture_value;

  modport source (output valid, output req_type, output capture_value, input ready);
  modport sink   (input valid, input req_type, input capture_value, output ready);
endinterface

interface rfm_out_if;
  logic                          valid;
  logic                          ready;
  logic [rfm_pkg::FREQ_W-1:0]    frequency_hz;
  logic [rfm_pkg::PERIOD_W-1:0]  period_cycles;
  logic                          period_zero;

  modport source (output valid, output frequency_hz, output period_cycles,
                  output period_zero, input ready);
  modport sink   (input valid, input frequency_hz, input period_cycles,
                  input period_zero, output ready);
endinterface

`default_nettype wire

// ===== rtl/reciprocal_frequency_meter_core.sv =====
// reciprocal frequency meter: wrap counting, period forming and bit-serial divide
// depends on rfm_pkg and the channel interfaces in rfm_if.sv
//
// A wrap item is accepted while idle and yields no result. A capture item is
// accepted, its period is formed with a single wide subtract, the quotient is
// then formed one bit per step in the restoring divide step, and the
// result is loaded into the output register when it is free or read. A zero or
// negative period skips the divide. The input is not ready from a capture's
// acceptance until its result has been loaded; a held result in the output
// register does not block new items until the next result is due.
`default_nettype none

module reciprocal_frequency_meter_core #(
  parameter int unsigned COUNTER_BITS = rfm_pkg::COUNTER_BITS,
  parameter int unsigned WRAP_BITS    = rfm_pkg::WRAP_BITS
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_we,
  input  wire logic [rfm_pkg::FREQ_W-1:0]   cfg_wdata,
  rfm_in_if.sink                            in_ch,
  rfm_out_if.source                         out_ch
);

  localparam int unsigned FW    = rfm_pkg::FREQ_W;
  localparam int unsigned PW    = rfm_pkg::PERIOD_W;
  localparam int unsigned SUM_W = WRAP_BITS + COUNTER_BITS;
  localparam int unsigned EXT_W = (SUM_W > PW) ? SUM_W : PW + 1;
  localparam int unsigned CNT_W = $clog2(FW);

  rfm_pkg::state_t state;

  logic [FW-1:0]           ref_clock_hz;
  logic [COUNTER_BITS-1:0] previous_capture;
  logic [WRAP_BITS-1:0]    wrap_count;
  logic [COUNTER_BITS-1:0] cap;
  logic [PW-1:0]           divisor;
  logic [PW-1:0]           rem;
  logic [FW-1:0]           quot;
  logic                    zero;
  logic [CNT_W-1:0]        cnt;

  logic                    out_valid;
  logic [FW-1:0]           out_freq;
  logic [PW-1:0]           out_period;
  logic                    out_zero;

  logic [rfm_pkg::CAP_W+COUNTER_BITS-1:0] cap_wide;
  logic [COUNTER_BITS-1:0] cap_in;
  logic [EXT_W-1:0]        sum_ext;
  logic [EXT_W:0]          diff;
  logic                    neg;
  logic                    sat;
  logic [PW-1:0]           period_next;
  logic [PW:0]             trial;
  logic [PW:0]             trial_sub;
  logic                    accept;
  logic                    load_out;

  // capture bits above the counter width are dropped
  assign cap_wide = {{COUNTER_BITS{1'b0}}, in_ch.capture_value};
  assign cap_in   = cap_wide[COUNTER_BITS-1:0];

  assign sum_ext = EXT_W'({wrap_count, cap});
  assign diff    = {1'b0, sum_ext} - (EXT_W+1)'(previous_capture);
  assign neg     = diff[EXT_W];
  assign sat     = |diff[EXT_W-1:PW];

  always_comb begin
    if (neg) begin
      period_next = '0;
    end else if (sat) begin
      period_next = '1;
    end else begin
      period_next = diff[PW-1:0];
    end
  end

  // one restoring divide step
  assign trial     = {rem, quot[FW-1]};
  assign trial_sub = trial - {1'b0, divisor};

  assign accept   = in_ch.valid && in_ch.ready;
  assign load_out = (state == rfm_pkg::ST_DONE) && (!out_valid || out_ch.ready);

  assign in_ch.ready          = (state == rfm_pkg::ST_IDLE);
  assign out_ch.valid         = out_valid;
  assign out_ch.frequency_hz  = out_freq;
  assign out_ch.period_cycles = out_period;
  assign out_ch.period_zero   = out_zero;

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_clock_hz <= rfm_pkg::REF_CLOCK_RESET;
    end else if (cfg_we) begin
      ref_clock_hz <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= rfm_pkg::ST_IDLE;
      previous_capture <= '0;
      wrap_count       <= '0;
      cnt              <= '0;
    end else begin
      case (state)
        rfm_pkg::ST_IDLE: begin
          if (accept) begin
            if (in_ch.req_type == rfm_pkg::REQ_CAPTURE) begin
              state <= rfm_pkg::ST_CALC;
            end else if (wrap_count != '1) begin
              wrap_count <= wrap_count + 1'b1;
            end
          end
        end
        rfm_pkg::ST_CALC: begin
          previous_capture <= cap;
          wrap_count       <= '0;
          cnt              <= '0;
          state            <= (period_next == '0) ? rfm_pkg::ST_DONE : rfm_pkg::ST_DIV;
        end
        rfm_pkg::ST_DIV: begin
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(FW - 1)) begin
            state <= rfm_pkg::ST_DONE;
          end
        end
        rfm_pkg::ST_DONE: begin
          if (load_out) begin
            state <= rfm_pkg::ST_IDLE;
          end
        end
        default: begin
          state <= rfm_pkg::ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cap <= cap_in;
    end
    if (state == rfm_pkg::ST_CALC) begin
      divisor <= period_next;
      zero    <= (period_next == '0);
      rem     <= '0;
      quot    <= (period_next == '0) ? '0 : ref_clock_hz;
    end else if (state == rfm_pkg::ST_DIV) begin
      if (!trial_sub[PW]) begin
        rem  <= trial_sub[PW-1:0];
        quot <= {quot[FW-2:0], 1'b1};
      end else begin
        rem  <= trial[PW-1:0];
        quot <= {quot[FW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ch.ready) begin
        out_valid <= 1'b0;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_freq   <= quot;
      out_period <= divisor;
      out_zero   <= zero;
    end
  end

  // a new result appears only out of the load state
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == rfm_pkg::ST_DONE))
    else $error("result valid without load");

  // a wrap item never starts the sequencer
  assert property (@(posedge clk) disable iff (rst)
    accept && (in_ch.req_type == rfm_pkg::REQ_WRAP) |=> state == rfm_pkg::ST_IDLE)
    else $error("wrap item left idle");

  // wrap count is cleared once a capture has formed its period
  assert property (@(posedge clk) disable iff (rst)
    accept && (in_ch.req_type == rfm_pkg::REQ_CAPTURE) |=> ##1 wrap_count == '0)
    else $error("wrap count not cleared after capture");

  // a flagged zero period always carries a zero frequency and period
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_zero |-> (out_freq == '0) && (out_period == '0))
    else $error("zero period with nonzero result");

  // divide step counter stays within the quotient width
  assert property (@(posedge clk) disable iff (rst)
    state == rfm_pkg::ST_DIV |-> cnt <= CNT_W'(FW - 1))
    else $error("divide step count overrun");

endmodule

`default_nettype wire

// ===== tb/sv/reciprocal_frequency_meter_core_tb.sv =====
`timescale 1ns / 100ps
// self-checking testbench for reciprocal_frequency_meter_core: wrap and capture items in,
// frequency results out, each one checked against a period and divide predictor or a fixed expected value
// depends on rfm_pkg, the channel interfaces in rfm_if.sv and the core rtl

module reciprocal_frequency_meter_core_tb;
  import rfm_pkg::*;

  localparam int CLK_HALF       = 4;
  localparam int RESET_CYCLES   = 11;
  localparam int CYCLE_LIMIT    = 1500000;
  localparam int SETTLE_CYCLES  = 40;
  localparam int TAIL_CYCLES    = 100;
  localparam int PHASE_ITEMS    = 250;
  localparam int N_PHASES       = 6;
  localparam int RANDOM_PHASE   = 4;
  localparam int SATURATE_PHASE = 3;
  localparam int SATURATE_WRAPS = 65540;
  localparam int LONG_HOLD      = 500;
  localparam int HOLD_AT_FIRST  = 100;
  localparam int HOLD_AT_SECOND = 200;
  localparam int SEND_PCT [3]   = '{0, 30, 70};
  localparam int STALL_PCT [3]  = '{0, 25, 60};

  typedef struct packed {
    logic [FREQ_W-1:0]   frequency_hz;
    logic [PERIOD_W-1:0] period_cycles;
    logic                period_zero;
  } meas_t;

  typedef struct packed {
    logic             req_type;
    logic [CAP_W-1:0] capture_value;
    logic             fixed;
    meas_t            meas;
  } probe_t;

  localparam meas_t NO_MEAS   = '0;
  localparam meas_t ZERO_MEAS = '{'0, '0, 1'b1};
  localparam meas_t UNIT_MEAS = '{REF_CLOCK_RESET, 32'd1, 1'b0};

  localparam int N_PROBES = 21;
  localparam probe_t PROBES [N_PROBES] = '{
    '{REQ_CAPTURE, 16'h0000, 1'b1, ZERO_MEAS},
    '{REQ_CAPTURE, 16'h0001, 1'b1, UNIT_MEAS},
    '{REQ_CAPTURE, 16'h0000, 1'b1, ZERO_MEAS},  // capture below previous, no wrap
    '{REQ_CAPTURE, 16'hFFFF, 1'b0, NO_MEAS},
    '{REQ_WRAP,    16'h0000, 1'b0, NO_MEAS},
    '{REQ_CAPTURE, 16'hFFFF, 1'b0, NO_MEAS},
    '{REQ_WRAP,    16'hFFFF, 1'b0, NO_MEAS},  // capture field ignored on a wrap
    '{REQ_WRAP,    16'h5555, 1'b0, NO_MEAS},
    '{REQ_CAPTURE, 16'h0000, 1'b0, NO_MEAS},
    '{REQ_CAPTURE, 16'h5555, 1'b0, NO_MEAS},
    '{REQ_CAPTURE, 16'hAAAA, 1'b0, NO_MEAS},
    '{REQ_CAPTURE, 16'hAAAA, 1'b1, ZERO_MEAS},
    '{REQ_WRAP,    16'hAAAA, 1'b0, NO_MEAS},
    '{REQ_CAPTURE, 16'h0000, 1'b0, NO_MEAS},
    '{REQ_CAPTURE, 16'h8000, 1'b0, NO_MEAS},
    '{REQ_CAPTURE, 16'h7FFF, 1'b1, ZERO_MEAS},
    '{REQ_WRAP,    16'h0000, 1'b0, NO_MEAS},
    '{REQ_CAPTURE, 16'h7FFF, 1'b0, NO_MEAS},
    '{REQ_CAPTURE, 16'h8000, 1'b1, UNIT_MEAS},
    '{REQ_WRAP,    16'hFFFF, 1'b0, NO_MEAS},
    '{REQ_CAPTURE, 16'h8001, 1'b0, NO_MEAS}
  };

  logic              clk = 1'b0;
  logic              rst;
  logic              cfg_we;
  logic [FREQ_W-1:0] cfg_wdata;

  rfm_in_if  event_ch ();
  rfm_out_if result_ch ();

  logic [FREQ_W-1:0]       ref_hz = REF_CLOCK_RESET;
  logic [COUNTER_BITS-1:0] last_capture = '0;
  logic [WRAP_BITS-1:0]    wraps_seen = '0;
  meas_t                   expected_q [$];
  int                      fail_count = 0;
  int                      results_seen = 0;
  int                      cycle_count = 0;
  int                      send_pct = 0;

  reciprocal_frequency_meter_core DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (event_ch),
    .out_ch    (result_ch)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // advances the meter state by one item; returns 1 when the item yields a result
  function automatic logic measure(input logic kind, input logic [CAP_W-1:0] value,
                                   output meas_t m);
    logic [63:0] cap;
    logic [63:0] total;
    logic [63:0] span;
    m = '0;
    if (kind == REQ_WRAP) begin
      if (wraps_seen != '1) wraps_seen = wraps_seen + 1'b1;
      return 1'b0;
    end
    cap   = 64'(value) & ((64'd1 << COUNTER_BITS) - 64'd1);
    total = (64'(wraps_seen) << COUNTER_BITS) + cap;
    if (total < 64'(last_capture)) begin
      span = '0;
    end else begin
      span = total - 64'(last_capture);
      if (span > 64'hFFFF_FFFF) span = 64'hFFFF_FFFF;
    end
    m.period_zero   = (span == 0);
    m.period_cycles = span[PERIOD_W-1:0];
    m.frequency_hz  = (span == 0) ? '0 : FREQ_W'(64'(ref_hz) / span);
    wraps_seen   = '0;
    last_capture = cap[COUNTER_BITS-1:0];
    return 1'b1;
  endfunction

  // a gap with pct percent chance, else back to back; a gap is mostly short, rarely long
  function automatic int idle_gap(input int pct);
    if ($urandom_range(99) >= pct) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(40, 10);
    return $urandom_range(3, 1);
  endfunction

  function automatic int pick_wrap_run();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 80) return $urandom_range(2, 1);
    if (r < 98) return $urandom_range(12, 3);
    return $urandom_range(300, 20);
  endfunction

  function automatic logic [CAP_W-1:0] pick_capture();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      // close to the previous capture: tiny, zero and negative periods
      2, 3: return last_capture + CAP_W'($urandom_range(8)) - CAP_W'(4);
      default: return CAP_W'($urandom);
    endcase
  endfunction

  task automatic send_item(input logic kind, input logic [CAP_W-1:0] value,
                           input logic fixed = 1'b0, input meas_t typed = '0);
    int    gap;
    meas_t m;
    gap = idle_gap(send_pct);
    if (gap > 0) begin
      event_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    event_ch.valid         <= 1'b1;
    event_ch.req_type      <= kind;
    event_ch.capture_value <= value;
    @(posedge clk);
    while (!event_ch.ready) @(posedge clk);
    if (measure(kind, value, m)) expected_q.push_back(fixed ? typed : m);
  endtask

  task automatic wait_drained();
    event_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_ref_clock(input logic [FREQ_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    ref_hz = value;
  endtask

  initial begin : stimulus
    logic [FREQ_W-1:0] ref_plan [N_PHASES];
    int                sent;
    int                wrap_run;
    bit                paused;
    rst                    <= 1'b1;
    cfg_we                 <= 1'b0;
    cfg_wdata              <= '0;
    event_ch.valid         <= 1'b0;
    event_ch.req_type      <= REQ_WRAP;
    event_ch.capture_value <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    send_pct = SEND_PCT[1];
    for (int i = 0; i < N_PROBES; i++) begin
      send_item(PROBES[i].req_type, PROBES[i].capture_value, PROBES[i].fixed, PROBES[i].meas);
    end
    wait_drained();

    ref_plan = '{26'd50000000, 26'd1, 26'd0, 26'h3FFFFFF, 26'd0, REF_CLOCK_RESET};
    ref_plan[RANDOM_PHASE] = FREQ_W'($urandom_range(50000000, 1));
    for (int p = 0; p < N_PHASES; p++) begin
      write_ref_clock(ref_plan[p]);
      if (p == SATURATE_PHASE) begin
        // wrap count runs into its ceiling, then the longest possible period
        send_pct = 0;
        send_item(REQ_CAPTURE, '0);
        repeat (SATURATE_WRAPS) send_item(REQ_WRAP, CAP_W'($urandom));
        send_item(REQ_CAPTURE, '1);
      end
      send_pct = SEND_PCT[p % 3];
      sent     = 0;
      paused   = 1'b0;
      while (sent < PHASE_ITEMS) begin
        wrap_run = pick_wrap_run();
        repeat (wrap_run) send_item(REQ_WRAP, CAP_W'($urandom));
        send_item(REQ_CAPTURE, pick_capture());
        sent += wrap_run + 1;
        if (!paused && sent >= PHASE_ITEMS / 2) begin
          wait_drained();
          paused = 1'b1;
        end
      end
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin : result_check
    meas_t want;
    int    hold_left;
    int    gap;
    hold_left = 0;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst) begin
        if (result_ch.valid && result_ch.ready) begin
          if (expected_q.size() == 0) begin
            $error("result item with no capture outstanding: frequency_hz %0d period_cycles %0d",
                   result_ch.frequency_hz, result_ch.period_cycles);
            fail_count++;
          end else begin
            want = expected_q.pop_front();
            if (result_ch.frequency_hz !== want.frequency_hz) begin
              $error("frequency_hz: expected %0d, actual %0d",
                     want.frequency_hz, result_ch.frequency_hz);
              fail_count++;
            end
            if (result_ch.period_cycles !== want.period_cycles) begin
              $error("period_cycles: expected %0d, actual %0d",
                     want.period_cycles, result_ch.period_cycles);
              fail_count++;
            end
            if (result_ch.period_zero !== want.period_zero) begin
              $error("period_zero: expected %0d, actual %0d",
                     want.period_zero, result_ch.period_zero);
              fail_count++;
            end
          end
          results_seen++;
          // long back-pressure so the block fills up and stalls its input
          if (results_seen == HOLD_AT_FIRST || results_seen == HOLD_AT_SECOND) begin
            hold_left = LONG_HOLD;
          end
        end
        if (hold_left > 0) begin
          result_ch.ready <= 1'b0;
          hold_left--;
        end else begin
          gap = idle_gap(STALL_PCT[(results_seen / 64) % 3]);
          if (gap > 0) begin
            result_ch.ready <= 1'b0;
            hold_left = gap - 1;
          end else begin
            result_ch.ready <= 1'b1;
          end
        end
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAILURE");
    $finish;
  end

endmodule
